FILE: rtl/core/scancode_line_editor_top_defines.svh
// Assertion macros shared by the scan-code line editor checkers.
`ifndef SCANCODE_LINE_EDITOR_TOP_DEFINES_SVH
`define SCANCODE_LINE_EDITOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define SCL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define SCL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/scl_pkg.sv
// Shared types, codes, sizes and key maps of the scan-code line editor.
package scl_pkg;

	localparam int LINE_SIZE   = 64;
	localparam int IDX_W       = $clog2(LINE_SIZE);
	localparam int BYTE_W      = 8;
	localparam int CHAR_W      = 7;
	localparam int POS_W       = 6;
	localparam int EV_W        = 3;
	localparam int CMD_W       = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(LINE_SIZE - 1);

	localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
	localparam logic [EV_W-1:0] EV_INSERT = 3'd1;
	localparam logic [EV_W-1:0] EV_DELETE = 3'd2;
	localparam logic [EV_W-1:0] EV_MOVE   = 3'd3;
	localparam logic [EV_W-1:0] EV_CHAR   = 3'd4;
	localparam logic [EV_W-1:0] EV_SUBMIT = 3'd5;

	localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BKSP   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_INS    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SUBMIT = 3'd6;

	localparam logic [BYTE_W-1:0] SC_PREFIX    = 8'hE0;
	localparam logic [BYTE_W-1:0] SC_RELEASE   = 8'h80;
	localparam logic [BYTE_W-1:0] SC_CODE_MASK = 8'h7F;
	localparam logic [BYTE_W-1:0] SC_LEFT      = 8'h4B;
	localparam logic [BYTE_W-1:0] SC_RIGHT     = 8'h4D;
	localparam logic [BYTE_W-1:0] SC_DELETE    = 8'h53;
	localparam logic [BYTE_W-1:0] SC_LSHIFT    = 8'h2A;
	localparam logic [BYTE_W-1:0] SC_RSHIFT    = 8'h36;
	localparam logic [BYTE_W-1:0] SC_BKSP      = 8'h0E;
	localparam logic [BYTE_W-1:0] SC_ENTER     = 8'h1C;

	typedef struct packed {
		logic [CMD_W-1:0]  kind;
		logic [CHAR_W-1:0] ch;
	} cmd_t;

	localparam logic [CHAR_W-1:0] KEYMAP_LO [0:63] = '{
		7'd0,   7'd27,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,
		7'd55,  7'd56,  7'd57,  7'd48,  7'd45,  7'd61,  7'd8,   7'd9,
		7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
		7'd111, 7'd112, 7'd91,  7'd93,  7'd10,  7'd0,   7'd97,  7'd115,
		7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
		7'd39,  7'd96,  7'd0,   7'd92,  7'd122, 7'd120, 7'd99,  7'd118,
		7'd98,  7'd110, 7'd109, 7'd44,  7'd46,  7'd47,  7'd0,   7'd42,
		7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
	};

	localparam logic [CHAR_W-1:0] KEYMAP_HI [0:63] = '{
		7'd0,   7'd27,  7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,
		7'd38,  7'd42,  7'd40,  7'd41,  7'd95,  7'd43,  7'd8,   7'd9,
		7'd81,  7'd87,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,  7'd73,
		7'd79,  7'd80,  7'd123, 7'd125, 7'd10,  7'd0,   7'd65,  7'd83,
		7'd68,  7'd70,  7'd71,  7'd72,  7'd74,  7'd75,  7'd76,  7'd58,
		7'd34,  7'd126, 7'd0,   7'd124, 7'd90,  7'd88,  7'd67,  7'd86,
		7'd66,  7'd78,  7'd77,  7'd60,  7'd62,  7'd63,  7'd0,   7'd42,
		7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
	};

	function automatic logic [CHAR_W-1:0] keymap(input logic [6:0] code, input logic upper);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (!code[6]) begin
			ch = upper ? KEYMAP_HI[code[5:0]] : KEYMAP_LO[code[5:0]];
		end
		return ch;
	endfunction

endpackage

FILE: rtl/core/scancode_line_editor_top.sv
// Top level of the scan-code line editor: front end, command queue and edit engine.
//
// The block takes one set 1 scan byte per transfer on the scan channel and returns one or more
// results per byte on the result channel, the final one marked by last. The front end accepts a
// byte and queues up to two commands, so it keeps taking bytes while the edit engine works,
// until the queue is full. The edit engine answers a command that leaves the line as it is, or
// a cursor move, straight from idle; for an insert or a delete it then moves each character
// behind the cursor one at a time, as the single read port of the line memory allows. A submit
// reads each character of the line and then streams it out, holding while the result channel
// stalls, and ends with the end marker. No pass is needed after reset: the line memory is read
// only where it has been written.
module scancode_line_editor_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         scan_valid,
	output logic                         scan_stall,
	input  logic [scl_pkg::BYTE_W-1:0]   scan_byte,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [scl_pkg::EV_W-1:0]     event_res,
	output logic [scl_pkg::CHAR_W-1:0]   char_code,
	output logic [scl_pkg::POS_W-1:0]    cursor_pos,
	output logic [scl_pkg::POS_W-1:0]    line_length,
	output logic                         last
);
	import scl_pkg::*;

	logic push_valid;
	cmd_t push_cmd;
	logic queue_full;
	logic queue_empty;
	logic pop;
	cmd_t pop_cmd;

	scl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_valid (scan_valid),
		.scan_stall (scan_stall),
		.scan_byte  (scan_byte),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	scl_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_valid  (push_valid),
		.push_cmd    (push_cmd),
		.queue_full  (queue_full),
		.pop         (pop),
		.queue_empty (queue_empty),
		.pop_cmd     (pop_cmd)
	);

	scl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.pop_cmd     (pop_cmd),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.event_res   (event_res),
		.char_code   (char_code),
		.cursor_pos  (cursor_pos),
		.line_length (line_length),
		.last        (last)
	);

endmodule

FILE: rtl/core/scl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module scl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/core/scl_front.sv
// Front end: takes scan bytes, tracks shift, prefix and repeat state, and issues edit commands.
module scl_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          scan_valid,
	output logic                          scan_stall,
	input  logic [scl_pkg::BYTE_W-1:0]    scan_byte,
	output logic                          push_valid,
	output scl_pkg::cmd_t                 push_cmd,
	input  logic                          queue_full
);
	import scl_pkg::*;

	logic              shift_q, shift_d;
	logic              prefix_q, prefix_d;
	logic [BYTE_W-1:0] prev_q, prev_d;
	logic [BYTE_W-1:0] code;
	logic [CHAR_W-1:0] mapped;
	cmd_t              cmd;

	assign scan_stall = queue_full;
	assign push_valid = scan_valid && !queue_full;
	assign push_cmd   = cmd;
	assign code       = scan_byte & SC_CODE_MASK;
	assign mapped     = keymap(scan_byte[6:0], shift_q);

	always_comb begin
		shift_d  = shift_q;
		prefix_d = prefix_q;
		prev_d   = prev_q;
		cmd.kind = CMD_NONE;
		cmd.ch   = '0;
		if (scan_byte != prev_q) begin
			prev_d = scan_byte;
			if (scan_byte == SC_PREFIX) begin
				prefix_d = 1'b1;
			end else if ((scan_byte & SC_RELEASE) != '0) begin
				if (code == SC_LSHIFT || code == SC_RSHIFT) begin
					shift_d = 1'b0;
				end
				prev_d = '0;
			end else if (prefix_q) begin
				prefix_d = 1'b0;
				case (scan_byte)
					SC_LEFT:   cmd.kind = CMD_LEFT;
					SC_RIGHT:  cmd.kind = CMD_RIGHT;
					SC_DELETE: cmd.kind = CMD_DEL;
					default:   cmd.kind = CMD_NONE;
				endcase
			end else if (scan_byte == SC_LSHIFT || scan_byte == SC_RSHIFT) begin
				shift_d = 1'b1;
			end else if (scan_byte == SC_BKSP) begin
				cmd.kind = CMD_BKSP;
			end else if (scan_byte == SC_ENTER) begin
				cmd.kind = CMD_SUBMIT;
			end else if (mapped != '0) begin
				cmd.kind = CMD_INS;
				cmd.ch   = mapped;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			prefix_q <= 1'b0;
			prev_q   <= '0;
		end else if (push_valid) begin
			shift_q  <= shift_d;
			prefix_q <= prefix_d;
			prev_q   <= prev_d;
		end
	end

endmodule

FILE: rtl/core/scl_queue.sv
// Short command queue between the front end and the edit engine.
module scl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  scl_pkg::cmd_t push_cmd,
	output logic          queue_full,
	input  logic          pop,
	output logic          queue_empty,
	output scl_pkg::cmd_t pop_cmd
);
	import scl_pkg::*;

	cmd_t              entry_q [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign queue_full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign queue_empty = cnt_q == '0;
	assign pop_cmd     = entry_q[rd_ptr_q];
	assign do_push     = push_valid && !queue_full;
	assign do_pop      = pop && !queue_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/scl_back.sv
// Edit engine: applies commands to the line memory and drives the result register.
module scl_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         queue_empty,
	input  scl_pkg::cmd_t                pop_cmd,
	output logic                         pop,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [scl_pkg::EV_W-1:0]     event_res,
	output logic [scl_pkg::CHAR_W-1:0]   char_code,
	output logic [scl_pkg::POS_W-1:0]    cursor_pos,
	output logic [scl_pkg::POS_W-1:0]    line_length,
	output logic                         last
);
	import scl_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DEL     = 4'd1;
	localparam logic [3:0] ST_DEL_FIN = 4'd2;
	localparam logic [3:0] ST_INS     = 4'd3;
	localparam logic [3:0] ST_INS_FIN = 4'd4;
	localparam logic [3:0] ST_CHR     = 4'd5;
	localparam logic [3:0] ST_SUB_RD  = 4'd6;
	localparam logic [3:0] ST_SUB_OUT = 4'd7;
	localparam logic [3:0] ST_SUB_END = 4'd8;

	logic [3:0]        state_q, state_d;
	logic [IDX_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  cursor_q, cursor_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [IDX_W-1:0]  end_q, end_d;
	logic [IDX_W-1:0]  ins_pos_q, ins_pos_d;
	logic [CHAR_W-1:0] ins_char_q, ins_char_d;
	logic              pend_q, pend_d;
	logic [IDX_W-1:0]  pend_addr_q, pend_addr_d;

	logic              res_valid_q;
	logic [EV_W-1:0]   ev_q;
	logic [CHAR_W-1:0] ch_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  len_q;
	logic              last_q;

	logic              out_free;
	logic              emit;
	logic [EV_W-1:0]   emit_ev;
	logic [CHAR_W-1:0] emit_ch;
	logic              emit_last;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [CHAR_W-1:0] wr_data;
	logic              rd_en;
	logic [CHAR_W-1:0] rd_data;

	assign out_free    = !res_valid_q || !res_stall;
	assign res_valid   = res_valid_q;
	assign event_res   = ev_q;
	assign char_code   = ch_q;
	assign cursor_pos  = pos_q;
	assign line_length = len_q;
	assign last        = last_q;

	assign wr_en   = pend_q || (state_q == ST_CHR);
	assign wr_addr = pend_q ? pend_addr_q : ins_pos_q;
	assign wr_data = pend_q ? rd_data : ins_char_q;

	scl_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_SIZE)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cursor_d    = cursor_q;
		idx_d       = idx_q;
		end_d       = end_q;
		ins_pos_d   = ins_pos_q;
		ins_char_d  = ins_char_q;
		pend_d      = pend_q;
		pend_addr_d = pend_addr_q;
		emit        = 1'b0;
		emit_ev     = EV_NONE;
		emit_ch     = '0;
		emit_last   = 1'b1;
		pop         = 1'b0;
		rd_en       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!queue_empty && out_free) begin
					pop  = 1'b1;
					emit = 1'b1;
					case (pop_cmd.kind)
						CMD_LEFT: begin
							if (cursor_q != '0) begin
								cursor_d = cursor_q - 1'b1;
								emit_ev  = EV_MOVE;
							end
						end
						CMD_RIGHT: begin
							if (cursor_q < count_q) begin
								cursor_d = cursor_q + 1'b1;
								emit_ev  = EV_MOVE;
							end
						end
						CMD_DEL: begin
							if (cursor_q < count_q) begin
								emit_ev = EV_DELETE;
								count_d = count_q - 1'b1;
								if ((count_q - cursor_q) != IDX_W'(1)) begin
									idx_d   = cursor_q + 1'b1;
									end_d   = count_q - 1'b1;
									state_d = ST_DEL;
								end
							end
						end
						CMD_BKSP: begin
							if (cursor_q != '0) begin
								emit_ev  = EV_DELETE;
								count_d  = count_q - 1'b1;
								cursor_d = cursor_q - 1'b1;
								if (cursor_q < count_q) begin
									idx_d   = cursor_q;
									end_d   = count_q - 1'b1;
									state_d = ST_DEL;
								end
							end
						end
						CMD_INS: begin
							if (count_q < MAX_LEN) begin
								emit_ev    = EV_INSERT;
								emit_ch    = pop_cmd.ch;
								count_d    = count_q + 1'b1;
								cursor_d   = cursor_q + 1'b1;
								ins_pos_d  = cursor_q;
								ins_char_d = pop_cmd.ch;
								if (count_q != cursor_q) begin
									idx_d   = count_q - 1'b1;
									state_d = ST_INS;
								end else begin
									state_d = ST_CHR;
								end
							end
						end
						CMD_SUBMIT: begin
							emit     = 1'b0;
							count_d  = '0;
							cursor_d = '0;
							if (count_q != '0) begin
								idx_d   = '0;
								end_d   = count_q - 1'b1;
								state_d = ST_SUB_RD;
							end else begin
								state_d = ST_SUB_END;
							end
						end
						default: begin
							emit_ev = EV_NONE;
						end
					endcase
				end
			end
			ST_DEL: begin
				rd_en       = 1'b1;
				pend_d      = 1'b1;
				pend_addr_d = idx_q - 1'b1;
				if (idx_q == end_q) begin
					state_d = ST_DEL_FIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DEL_FIN: begin
				pend_d  = 1'b0;
				state_d = ST_IDLE;
			end
			ST_INS: begin
				rd_en       = 1'b1;
				pend_d      = 1'b1;
				pend_addr_d = idx_q + 1'b1;
				if (idx_q == ins_pos_q) begin
					state_d = ST_INS_FIN;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			ST_INS_FIN: begin
				pend_d  = 1'b0;
				state_d = ST_CHR;
			end
			ST_CHR: begin
				state_d = ST_IDLE;
			end
			ST_SUB_RD: begin
				rd_en   = 1'b1;
				state_d = ST_SUB_OUT;
			end
			ST_SUB_OUT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_ev   = EV_CHAR;
					emit_ch   = rd_data;
					emit_last = 1'b0;
					if (idx_q == end_q) begin
						state_d = ST_SUB_END;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_SUB_RD;
					end
				end
			end
			ST_SUB_END: begin
				if (out_free) begin
					emit    = 1'b1;
					emit_ev = EV_SUBMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
			pend_q   <= pend_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		end_q       <= end_d;
		ins_pos_q   <= ins_pos_d;
		ins_char_q  <= ins_char_d;
		pend_addr_q <= pend_addr_d;
		if (emit) begin
			ev_q   <= emit_ev;
			ch_q   <= emit_ch;
			pos_q  <= POS_W'(cursor_d);
			len_q  <= POS_W'(count_d);
			last_q <= emit_last;
		end
	end

endmodule

FILE: rtl/core/scl_checker.sv
// Port-level checks of the scan-code line editor results, bound to the top level.
`include "scancode_line_editor_top_defines.svh"

module scl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_stall,
	input logic [scl_pkg::EV_W-1:0]     event_res,
	input logic [scl_pkg::CHAR_W-1:0]   char_code,
	input logic [scl_pkg::POS_W-1:0]    cursor_pos,
	input logic [scl_pkg::POS_W-1:0]    line_length,
	input logic                         last
);
	import scl_pkg::*;

	`SCL_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(event_res) && $stable(char_code) && $stable(cursor_pos) && $stable(line_length) && $stable(last), "Stalled result changed.")
	`SCL_ASSERT_IMP(a_submit_clears, res_valid && (event_res == EV_CHAR || event_res == EV_SUBMIT), cursor_pos == '0 && line_length == '0, "Submit result with a nonempty line.")
	`SCL_ASSERT_IMP(a_last_marks, res_valid && event_res != EV_CHAR, last, "Single result without last.")
	`SCL_ASSERT_IMP(a_cursor_in_line, res_valid, cursor_pos <= line_length, "Cursor beyond the line end.")
	`SCL_ASSERT_IMP(a_insert_char, res_valid && event_res == EV_INSERT, char_code != '0 && line_length != '0, "Insert without a character.")

endmodule

bind scancode_line_editor_top scl_checker u_scl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.event_res   (event_res),
	.char_code   (char_code),
	.cursor_pos  (cursor_pos),
	.line_length (line_length),
	.last        (last)
);
